[hw/rtl/rate_to_quadrature_generator_assert.svh]
// Assertion macros for the rate to quadrature generator.
`ifndef RATE_TO_QUADRATURE_GENERATOR_ASSERT_SVH
`define RATE_TO_QUADRATURE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RQG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RQG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rqg_pkg.sv]
// Types and constants for the rate to quadrature generator.
package rqg_pkg;

  localparam int NUM_W          = 20;
  localparam int LIM_W          = 16;
  localparam int RATE_W         = 16;
  localparam int MAG_W          = 16;
  localparam int DIV_CNT_W      = $clog2(NUM_W);
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = NUM_W;
  localparam int PERIOD_BITS_DEF = 20;

  localparam logic [NUM_W-1:0] PERIOD_NUMERATOR_RST = NUM_W'(720000);
  localparam logic [LIM_W-1:0] LOW_LIMIT_RST        = LIM_W'(16);
  localparam logic [LIM_W-1:0] HIGH_LIMIT_RST       = LIM_W'(4480);

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_NUMERATOR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT        = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT       = CFG_IDX_W'(2);

  localparam logic FUNC_RATE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [RATE_W-1:0] rate;
  } in_t;

  typedef struct packed {
    logic line_a;
    logic line_b;
    logic running;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

[hw/rtl/rate_to_quadrature_generator.sv]
// Rate to quadrature generator: rate samples set a step period, ticks step the lines.
// Every request yields one result. A tick request or an out-of-band rate sample
// is answered straight from the idle state. An in-band rate sample passes through
// the accept cycle, a bit-serial restoring divider (one quotient bit of
// period_numerator / |rate| per cycle through a single shared subtractor), and
// a finish step that saturates the quotient and updates the generator. The input is
// stalled while a division runs or while an undelivered result waits.
module rate_to_quadrature_generator #(
  parameter int PERIOD_BITS = rqg_pkg::PERIOD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rqg_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rqg_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [rqg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rqg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  `include "rate_to_quadrature_generator_assert.svh"

  localparam int NUM_W  = rqg_pkg::NUM_W;
  localparam int MAG_W  = rqg_pkg::MAG_W;
  localparam int LIM_W  = rqg_pkg::LIM_W;
  localparam int CNT_W  = rqg_pkg::DIV_CNT_W;
  localparam int WIDE_W = (PERIOD_BITS > NUM_W) ? PERIOD_BITS : NUM_W;
  localparam logic [PERIOD_BITS-1:0] PERIOD_MASK = '1;

  rqg_pkg::state_t state_r, state_nxt;

  logic [NUM_W-1:0]       period_num_r;
  logic [LIM_W-1:0]       low_limit_r, high_limit_r;
  logic [PERIOD_BITS-1:0] step_period_r, step_period_nxt;
  logic [PERIOD_BITS-1:0] tick_count_r, tick_count_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic                   reverse_r, reverse_nxt;
  logic                   active_r, active_nxt;
  logic                   level_a_r, level_a_nxt;
  logic                   level_b_r, level_b_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic [NUM_W-1:0]       quo_r, quo_nxt;
  logic [MAG_W-1:0]       rem_r, rem_nxt;
  logic [MAG_W-1:0]       dvs_r, dvs_nxt;

  logic                   in_acc, out_acc;
  logic                   rate_neg;
  logic [MAG_W-1:0]       rate_mag;
  logic                   in_band;
  logic [MAG_W:0]         rem_sh;
  logic [MAG_W+1:0]       trial;
  logic [WIDE_W-1:0]      q_wide;
  logic [PERIOD_BITS-1:0] q_sat, q_fin;
  logic [PERIOD_BITS-1:0] tick_inc;
  logic [1:0]             ph_adv;
  logic                   adv_a, adv_b;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign in_stall = !rst_n || (state_r != rqg_pkg::ST_IDLE) || (out_valid_r && out_stall);

  assign out_valid        = out_valid_r;
  assign out_data.line_a  = level_a_r;
  assign out_data.line_b  = level_b_r;
  assign out_data.running = active_r;

  assign rate_neg = in_data.rate[rqg_pkg::RATE_W-1];
  assign rate_mag = rate_neg ? MAG_W'(-in_data.rate) : MAG_W'(in_data.rate);
  assign in_band  = (rate_mag > low_limit_r) && (rate_mag < high_limit_r);

  // restoring divide step
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_r};

  // quotient saturation and zero fixup
  assign q_wide = WIDE_W'(quo_r);
  assign q_sat  = (q_wide > WIDE_W'(PERIOD_MASK)) ? PERIOD_MASK : PERIOD_BITS'(q_wide);
  assign q_fin  = (q_sat == '0) ? PERIOD_BITS'(1) : q_sat;

  assign tick_inc = (tick_count_r != PERIOD_MASK) ? tick_count_r + PERIOD_BITS'(1)
                                                  : tick_count_r;
  assign ph_adv   = phase_r + 2'd1;

  always_comb begin
    unique case (ph_adv)
      2'd1: begin
        adv_a = 1'b1;
        adv_b = 1'b1;
      end
      2'd2: begin
        adv_a = !reverse_r;
        adv_b = reverse_r;
      end
      2'd3: begin
        adv_a = 1'b0;
        adv_b = 1'b0;
      end
      default: begin
        adv_a = reverse_r;
        adv_b = !reverse_r;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    step_period_nxt = step_period_r;
    tick_count_nxt  = tick_count_r;
    phase_nxt       = phase_r;
    reverse_nxt     = reverse_r;
    active_nxt      = active_r;
    level_a_nxt     = level_a_r;
    level_b_nxt     = level_b_r;
    neg_nxt         = neg_r;
    cnt_nxt         = cnt_r;
    quo_nxt         = quo_r;
    rem_nxt         = rem_r;
    dvs_nxt         = dvs_r;
    out_valid_nxt   = out_valid_r && !out_acc;

    unique case (state_r)
      rqg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.func == rqg_pkg::FUNC_TICK) begin
            out_valid_nxt = 1'b1;
            if (active_r) begin
              if (tick_inc >= step_period_r) begin
                tick_count_nxt = '0;
                phase_nxt      = ph_adv;
                level_a_nxt    = adv_a;
                level_b_nxt    = adv_b;
              end else begin
                tick_count_nxt = tick_inc;
              end
            end
          end else if (in_band) begin
            neg_nxt   = rate_neg;
            quo_nxt   = period_num_r;
            rem_nxt   = '0;
            dvs_nxt   = rate_mag;
            cnt_nxt   = CNT_W'(NUM_W - 1);
            state_nxt = rqg_pkg::ST_DIV;
          end else begin
            active_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
          end
        end
      end
      rqg_pkg::ST_DIV: begin
        if (trial[MAG_W+1]) begin
          rem_nxt = rem_sh[MAG_W-1:0];
        end else begin
          rem_nxt = trial[MAG_W-1:0];
        end
        quo_nxt = {quo_r[NUM_W-2:0], !trial[MAG_W+1]};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = rqg_pkg::ST_FIN;
        end
      end
      rqg_pkg::ST_FIN: begin
        step_period_nxt = q_fin;
        reverse_nxt     = neg_r;
        if (!active_r) begin
          tick_count_nxt = '0;
        end
        active_nxt    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = rqg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rqg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rqg_pkg::ST_IDLE;
      period_num_r  <= rqg_pkg::PERIOD_NUMERATOR_RST;
      low_limit_r   <= rqg_pkg::LOW_LIMIT_RST;
      high_limit_r  <= rqg_pkg::HIGH_LIMIT_RST;
      step_period_r <= '0;
      tick_count_r  <= '0;
      phase_r       <= '0;
      reverse_r     <= 1'b0;
      active_r      <= 1'b0;
      level_a_r     <= 1'b0;
      level_b_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      neg_r         <= 1'b0;
      cnt_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      step_period_r <= step_period_nxt;
      tick_count_r  <= tick_count_nxt;
      phase_r       <= phase_nxt;
      reverse_r     <= reverse_nxt;
      active_r      <= active_nxt;
      level_a_r     <= level_a_nxt;
      level_b_r     <= level_b_nxt;
      out_valid_r   <= out_valid_nxt;
      neg_r         <= neg_nxt;
      cnt_r         <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rqg_pkg::CFG_PERIOD_NUMERATOR: period_num_r <= cfg_data;
          rqg_pkg::CFG_LOW_LIMIT:        low_limit_r  <= cfg_data[LIM_W-1:0];
          rqg_pkg::CFG_HIGH_LIMIT:       high_limit_r <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  `RQG_ASSERT_NOW(a_busy_no_result, state_r != rqg_pkg::ST_IDLE, !out_valid_r, "result pending during divide")
  `RQG_ASSERT_NOW(a_active_period, active_r, step_period_r != '0, "active with zero period")
  `RQG_ASSERT_NEXT(a_fin_done, state_r == rqg_pkg::ST_FIN, out_valid_r && active_r, "finish left no running result")
  `RQG_ASSERT_NOW(a_fin_from_div, state_r == rqg_pkg::ST_FIN, $past(state_r) == rqg_pkg::ST_DIV && $past(cnt_r) == '0, "finish without full divide")

endmodule

[test/tb.sv]
// Self-checking testbench for the rate to quadrature generator.
module tb;

  localparam logic [19:0] PERIOD_MAX = 20'hFFFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rqg_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  rqg_pkg::out_t out_data;
  logic cfg_we;
  logic [rqg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rqg_pkg::CFG_DATA_W-1:0] cfg_data;

  rate_to_quadrature_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rqg_pkg::in_t req_queue[$];
  rqg_pkg::out_t lines_expected[$];
  int err_count;
  bit calm;
  bit in_fire;
  bit out_fire;
  int in_gap;
  int out_hold;

  // shadow of the configuration and generator state
  logic [19:0] numer_q;
  logic [15:0] low_q;
  logic [15:0] high_q;
  logic [19:0] step_period;
  logic [19:0] tick_count;
  logic [1:0] step_phase;
  logic dir_rev;
  logic gen_active;
  logic lev_a;
  logic lev_b;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic rqg_pkg::out_t predict_lines(rqg_pkg::in_t req);
    logic [16:0] mag;
    logic [31:0] quo;
    rqg_pkg::out_t res;
    if (req.func == rqg_pkg::FUNC_RATE) begin
      mag = req.rate[15] ? (17'h10000 - {1'b0, req.rate}) : {1'b0, req.rate};
      if (mag > {1'b0, low_q} && mag < {1'b0, high_q}) begin
        quo = {12'd0, numer_q} / {15'd0, mag};
        if (quo > {12'd0, PERIOD_MAX}) quo = {12'd0, PERIOD_MAX};
        if (quo == 0) quo = 1;
        step_period = quo[19:0];
        dir_rev = req.rate[15];
        if (!gen_active) tick_count = '0;
        gen_active = 1'b1;
      end else begin
        gen_active = 1'b0;
      end
    end else if (gen_active) begin
      if (tick_count < PERIOD_MAX) tick_count = tick_count + 1'b1;
      if (tick_count >= step_period) begin
        tick_count = '0;
        step_phase = step_phase + 1'b1;
        case (step_phase)
          2'd1: begin lev_a = 1'b1; lev_b = 1'b1; end
          2'd3: begin lev_a = 1'b0; lev_b = 1'b0; end
          2'd2: begin lev_a = ~dir_rev; lev_b = dir_rev; end
          default: begin lev_a = dir_rev; lev_b = ~dir_rev; end
        endcase
      end
    end
    res.line_a = lev_a;
    res.line_b = lev_b;
    res.running = gen_active;
    return res;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (req_queue.size() > 0) begin
          in_data <= req_queue.pop_front();
          in_valid <= 1'b1;
          in_gap <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin : out_drv
    int h;
    if (rst_n) begin
      h = out_fire ? draw_gap() : out_hold;
      if (h > 0) begin
        out_stall <= 1'b1;
        out_hold <= h - 1;
      end else begin
        out_stall <= 1'b0;
        out_hold <= 0;
      end
    end
  end

  // monitor: check results first, then predict the accepted request
  always @(posedge clk) begin : mon
    rqg_pkg::out_t want;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (out_fire) begin
      if (lines_expected.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected, got %b", $time, out_data);
      end else begin
        want = lines_expected.pop_front();
        if (out_data.line_a !== want.line_a) begin
          err_count++;
          $display("%0t: line_a expected %b got %b", $time, want.line_a, out_data.line_a);
        end
        if (out_data.line_b !== want.line_b) begin
          err_count++;
          $display("%0t: line_b expected %b got %b", $time, want.line_b, out_data.line_b);
        end
        if (out_data.running !== want.running) begin
          err_count++;
          $display("%0t: running expected %b got %b", $time, want.running,
                   out_data.running);
        end
      end
    end
    if (in_fire) lines_expected.push_back(predict_lines(in_data));
  end

  task automatic write_reg(logic [rqg_pkg::CFG_IDX_W-1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rqg_pkg::CFG_PERIOD_NUMERATOR: numer_q = val;
      rqg_pkg::CFG_LOW_LIMIT: low_q = val[15:0];
      rqg_pkg::CFG_HIGH_LIMIT: high_q = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_band(logic [19:0] numer, logic [15:0] lo, logic [15:0] hi);
    write_reg(rqg_pkg::CFG_PERIOD_NUMERATOR, numer);
    write_reg(rqg_pkg::CFG_LOW_LIMIT, {4'd0, lo});
    write_reg(rqg_pkg::CFG_HIGH_LIMIT, {4'd0, hi});
  endtask

  task automatic push_rate(int r);
    rqg_pkg::in_t req;
    req.func = rqg_pkg::FUNC_RATE;
    req.rate = r[15:0];
    req_queue.push_back(req);
  endtask

  task automatic push_tick(int n);
    rqg_pkg::in_t req;
    for (int i = 0; i < n; i++) begin
      req.func = rqg_pkg::FUNC_TICK;
      req.rate = 16'($urandom_range(0, 65535));
      req_queue.push_back(req);
    end
  endtask

  // sampled at the rising edge, where driver updates have settled
  task automatic wait_idle();
    @(posedge clk);
    while (req_queue.size() != 0 || in_valid || lines_expected.size() != 0)
      @(posedge clk);
    repeat (24) @(negedge clk);
  endtask

  initial begin
    int pick;
    int lo_mag;
    int hi_mag;
    int mag;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    calm = 1'b0;
    in_gap = 0;
    out_hold = 0;
    numer_q = rqg_pkg::PERIOD_NUMERATOR_RST;
    low_q = rqg_pkg::LOW_LIMIT_RST;
    high_q = rqg_pkg::HIGH_LIMIT_RST;
    step_period = '0;
    tick_count = '0;
    step_phase = '0;
    dir_rev = 1'b0;
    gen_active = 1'b0;
    lev_a = 1'b0;
    lev_b = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset band: idle tick, band edges, most negative rate
    push_tick(1);
    push_rate(0);
    push_rate(16);
    push_rate(4480);
    push_rate(4479);
    push_tick(2);
    push_rate(-32768);
    push_tick(1);
    wait_idle();

    // zero quotient, both directions, stop and hold
    set_band(20'd1, 16'd0, 16'hFFFF);
    push_rate(32767);
    push_tick(4);
    push_rate(-1);
    push_tick(2);
    push_rate(-32768);
    push_tick(1);
    push_rate(0);
    push_tick(1);
    wait_idle();

    // widest period
    write_reg(rqg_pkg::CFG_PERIOD_NUMERATOR, 20'hFFFFF);
    push_rate(1);
    push_tick(2);
    wait_idle();

    // period shrinks below kept count; restart from idle clears count
    set_band(20'd20, 16'd0, 16'd100);
    push_rate(2);
    push_tick(5);
    push_rate(10);
    push_tick(2);
    push_rate(0);
    push_tick(1);
    push_rate(-4);
    push_tick(5);
    wait_idle();

    // empty band
    set_band(20'd0, 16'hFFFF, 16'd0);
    push_rate(-32768);
    push_rate(32767);
    push_rate(100);
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph % 4 == 3);
      case (ph % 3)
        0: set_band(20'($urandom_range(1, 64)), 16'($urandom_range(0, 3)),
                    16'($urandom_range(8, 200)));
        1: set_band(20'($urandom_range(16384, 65535)), 16'($urandom_range(8192, 16000)),
                    16'hFFFF);
        default: set_band(20'($urandom_range(20'hF0000, 20'hFFFFF)),
                          16'($urandom_range(20000, 30000)),
                          16'($urandom_range(32769, 65535)));
      endcase
      lo_mag = low_q + 1;
      hi_mag = (high_q - 1 < 32768) ? high_q - 1 : 32768;
      for (int k = 0; k < 145; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          push_tick(1);
        end else if (pick < 94) begin
          mag = $urandom_range(lo_mag, hi_mag);
          if (mag == 32768 || $urandom_range(0, 1)) push_rate(-mag);
          else push_rate(mag);
        end else begin
          push_rate($urandom_range(0, 65535));
        end
      end
      wait_idle();
    end

    if (err_count == 0 && lines_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rqg_pkg.sv
hw/rtl/rate_to_quadrature_generator.sv
test/tb.sv
